// ===== rtl/core/i2cms_pkg.sv =====
package i2cms_pkg;

    typedef enum logic [1:0] {
        OP_START_WR = 2'd0,
        OP_START_RD = 2'd1,
        OP_EVENT    = 2'd2,
        OP_ERROR    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_READY = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_START    = 3'd1,
        ACT_REJECT   = 3'd2,
        ACT_TX_DONE  = 3'd3,
        ACT_RX_DONE  = 3'd4,
        ACT_ERR_END  = 3'd5
    } t_action;

    // status bit positions
    localparam int ST_SB   = 0;
    localparam int ST_ADDR = 1;
    localparam int ST_BTF  = 2;
    localparam int ST_RXNE = 3;
    localparam int ST_TXE  = 4;
    localparam int ST_BERR = 5;
    localparam int ST_ARLO = 6;
    localparam int ST_AF   = 7;
    localparam int ST_OVR  = 8;

    // error flag positions
    localparam int ERR_BUS  = 0;
    localparam int ERR_ARB  = 1;
    localparam int ERR_NACK = 2;
    localparam int ERR_OVR  = 3;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] dev_addr;
        logic [7:0] xfer_len;
        logic [8:0] status;
        logic [7:0] rx_byte;
        logic [7:0] tx_byte;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       dr_write;
        logic [7:0] dr_value;
        logic       stop_request;
        logic       ack_clear;
        logic       ack_set;
        logic       rx_valid;
        logic [7:0] rx_index;
        logic [7:0] rx_data;
        logic [3:0] error_flags;
        logic [1:0] busy_state;
    } t_res;

endpackage

// ===== rtl/core/i2cms_if.sv =====
interface i2cms_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [6:0] dev_addr;
    logic [7:0] xfer_len;
    logic [8:0] status;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;

    modport source (output valid, output op, output dev_addr, output xfer_len,
                    output status, output rx_byte, output tx_byte, input ready);
    modport sink   (input valid, input op, input dev_addr, input xfer_len,
                    input status, input rx_byte, input tx_byte, output ready);
endinterface

interface i2cms_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic       dr_write;
    logic [7:0] dr_value;
    logic       stop_request;
    logic       ack_clear;
    logic       ack_set;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic [7:0] rx_data;
    logic [3:0] error_flags;
    logic [1:0] busy_state;

    modport source (output valid, output action, output dr_write, output dr_value,
                    output stop_request, output ack_clear, output ack_set,
                    output rx_valid, output rx_index, output rx_data,
                    output error_flags, output busy_state, input ready);
    modport sink   (input valid, input action, input dr_write, input dr_value,
                    input stop_request, input ack_clear, input ack_set,
                    input rx_valid, input rx_index, input rx_data,
                    input error_flags, input busy_state, output ready);
endinterface

// ===== rtl/core/i2cms_step.sv =====
module i2cms_step #(
    parameter int LEN_WIDTH = 8
) (
    input  i2cms_pkg::t_cmd         i_cmd,
    input  i2cms_pkg::t_mode        i_mode,
    input  logic [6:0]              i_slave_addr,
    input  logic [LEN_WIDTH-1:0]    i_total_len,
    input  logic [LEN_WIDTH-1:0]    i_remaining,
    input  logic [3:0]              i_errors,
    output i2cms_pkg::t_mode        o_mode,
    output logic [6:0]              o_slave_addr,
    output logic [LEN_WIDTH-1:0]    o_total_len,
    output logic [LEN_WIDTH-1:0]    o_remaining,
    output logic [3:0]              o_errors,
    output i2cms_pkg::t_res         o_res
);

    logic [LEN_WIDTH-1:0] len;
    logic [LEN_WIDTH-1:0] rem_dec;
    logic [LEN_WIDTH-1:0] rx_pos;
    logic                 is_read;

    assign len     = LEN_WIDTH'(i_cmd.xfer_len);
    assign rem_dec = i_remaining - LEN_WIDTH'(1);
    assign rx_pos  = i_total_len - i_remaining;
    assign is_read = (i_cmd.op == i2cms_pkg::OP_START_RD);

    always_comb begin
        o_mode       = i_mode;
        o_slave_addr = i_slave_addr;
        o_total_len  = i_total_len;
        o_remaining  = i_remaining;
        o_errors     = i_errors;
        o_res        = '0;

        unique case (i2cms_pkg::t_op'(i_cmd.op))
            i2cms_pkg::OP_START_WR, i2cms_pkg::OP_START_RD: begin
                if (i_mode != i2cms_pkg::MODE_READY || (is_read && len == '0)) begin
                    o_res.action = i2cms_pkg::ACT_REJECT;
                end else begin
                    o_slave_addr = i_cmd.dev_addr;
                    o_total_len  = len;
                    o_remaining  = len;
                    o_errors     = '0;
                    o_mode       = is_read ? i2cms_pkg::MODE_READ : i2cms_pkg::MODE_WRITE;
                    o_res.ack_set = is_read;
                    o_res.action  = i2cms_pkg::ACT_START;
                end
            end
            i2cms_pkg::OP_EVENT: begin
                if (i_cmd.status[i2cms_pkg::ST_SB]) begin
                    o_res.dr_write = 1'b1;
                    o_res.dr_value = {i_slave_addr, i_mode != i2cms_pkg::MODE_WRITE};
                end else if (i_cmd.status[i2cms_pkg::ST_ADDR]) begin
                    if (i_mode == i2cms_pkg::MODE_READ && i_remaining == LEN_WIDTH'(1)) begin
                        o_res.ack_clear    = 1'b1;
                        o_res.stop_request = 1'b1;
                    end
                end else if (i_cmd.status[i2cms_pkg::ST_TXE]
                             && i_mode == i2cms_pkg::MODE_WRITE) begin
                    if (i_remaining != '0) begin
                        o_res.dr_write = 1'b1;
                        o_res.dr_value = i_cmd.tx_byte;
                        o_remaining    = rem_dec;
                    end else if (i_cmd.status[i2cms_pkg::ST_BTF]) begin
                        o_res.stop_request = 1'b1;
                        o_mode             = i2cms_pkg::MODE_READY;
                        o_res.action       = i2cms_pkg::ACT_TX_DONE;
                    end
                end else if (i_cmd.status[i2cms_pkg::ST_RXNE]
                             && i_mode == i2cms_pkg::MODE_READ) begin
                    o_res.rx_valid = 1'b1;
                    o_res.rx_index = 8'(rx_pos);
                    o_res.rx_data  = i_cmd.rx_byte;
                    o_remaining    = rem_dec;
                    // nack and stop ahead of the last byte
                    if (rem_dec == LEN_WIDTH'(1)) begin
                        o_res.ack_clear    = 1'b1;
                        o_res.stop_request = 1'b1;
                    end
                    if (rem_dec == '0) begin
                        o_mode       = i2cms_pkg::MODE_READY;
                        o_res.action = i2cms_pkg::ACT_RX_DONE;
                    end
                end
            end
            i2cms_pkg::OP_ERROR: begin
                o_errors[i2cms_pkg::ERR_BUS]  = i_errors[i2cms_pkg::ERR_BUS]
                                              | i_cmd.status[i2cms_pkg::ST_BERR];
                o_errors[i2cms_pkg::ERR_ARB]  = i_errors[i2cms_pkg::ERR_ARB]
                                              | i_cmd.status[i2cms_pkg::ST_ARLO];
                o_errors[i2cms_pkg::ERR_NACK] = i_errors[i2cms_pkg::ERR_NACK]
                                              | i_cmd.status[i2cms_pkg::ST_AF];
                o_errors[i2cms_pkg::ERR_OVR]  = i_errors[i2cms_pkg::ERR_OVR]
                                              | i_cmd.status[i2cms_pkg::ST_OVR];
                o_res.stop_request = i_cmd.status[i2cms_pkg::ST_AF];
                o_mode             = i2cms_pkg::MODE_READY;
                o_res.action       = i2cms_pkg::ACT_ERR_END;
            end
            default: begin
                o_res = '0;
            end
        endcase

        o_res.error_flags = o_errors;
        o_res.busy_state  = o_mode;
    end

endmodule

// ===== rtl/core/i2c_master_event_sequencer_core.sv =====
// channel  | dir | beat
// ---------+-----+---------------------------------------------------------
// i_in     | in  | op, dev_addr, xfer_len, status, rx_byte, tx_byte
// o_out    | out | action, dr_write/value, stop/ack controls, rx beat, flags
//
// one beat per cycle sustained while the result is not stalled; the path runs:
// an input register, then the step logic into the result register
// transfer state updates as the result register loads, so back-to-back beats
// see each other's effects without a bubble
// a stalled result holds the input register; i_in.ready drops only then
// synchronous active-low reset returns the sequencer to ready with zero state
module i2c_master_event_sequencer_core #(
    parameter int LEN_WIDTH = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    i2cms_in_if.sink    i_in,
    i2cms_out_if.source o_out
);

    i2cms_pkg::t_cmd      r_cmd;
    logic                 r_cmd_vld;
    i2cms_pkg::t_res      r_res;
    logic                 r_res_vld;

    i2cms_pkg::t_mode     r_mode;
    logic [6:0]           r_slave_addr;
    logic [LEN_WIDTH-1:0] r_total_len;
    logic [LEN_WIDTH-1:0] r_remaining;
    logic [3:0]           r_errors;

    i2cms_pkg::t_mode     n_mode;
    logic [6:0]           n_slave_addr;
    logic [LEN_WIDTH-1:0] n_total_len;
    logic [LEN_WIDTH-1:0] n_remaining;
    logic [3:0]           n_errors;
    i2cms_pkg::t_res      n_res;

    logic advance;
    logic in_take;

    assign advance   = r_cmd_vld && (!r_res_vld || o_out.ready);
    assign i_in.ready = !r_cmd_vld || advance;
    assign in_take   = i_in.valid && i_in.ready;

    i2cms_step #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_step (
        .i_cmd        (r_cmd),
        .i_mode       (r_mode),
        .i_slave_addr (r_slave_addr),
        .i_total_len  (r_total_len),
        .i_remaining  (r_remaining),
        .i_errors     (r_errors),
        .o_mode       (n_mode),
        .o_slave_addr (n_slave_addr),
        .o_total_len  (n_total_len),
        .o_remaining  (n_remaining),
        .o_errors     (n_errors),
        .o_res        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
        end else if (in_take) begin
            r_cmd_vld <= 1'b1;
        end else if (advance) begin
            r_cmd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd.op       <= i_in.op;
            r_cmd.dev_addr <= i_in.dev_addr;
            r_cmd.xfer_len <= i_in.xfer_len;
            r_cmd.status   <= i_in.status;
            r_cmd.rx_byte  <= i_in.rx_byte;
            r_cmd.tx_byte  <= i_in.tx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (advance) begin
            r_res_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= i2cms_pkg::MODE_READY;
            r_slave_addr <= '0;
            r_total_len  <= '0;
            r_remaining  <= '0;
            r_errors     <= '0;
        end else if (advance) begin
            r_mode       <= n_mode;
            r_slave_addr <= n_slave_addr;
            r_total_len  <= n_total_len;
            r_remaining  <= n_remaining;
            r_errors     <= n_errors;
        end
    end

    assign o_out.valid        = r_res_vld;
    assign o_out.action       = r_res.action;
    assign o_out.dr_write     = r_res.dr_write;
    assign o_out.dr_value     = r_res.dr_value;
    assign o_out.stop_request = r_res.stop_request;
    assign o_out.ack_clear    = r_res.ack_clear;
    assign o_out.ack_set      = r_res.ack_set;
    assign o_out.rx_valid     = r_res.rx_valid;
    assign o_out.rx_index     = r_res.rx_index;
    assign o_out.rx_data      = r_res.rx_data;
    assign o_out.error_flags  = r_res.error_flags;
    assign o_out.busy_state   = r_res.busy_state;

`ifndef SYNTH
    // the reported mode is the one the state register took with the beat
    a_mode_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (o_out.busy_state == r_mode))
        else $error("busy_state does not match the mode register");

    // a finished read or write, or an error end, always leaves the sequencer ready
    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.action == i2cms_pkg::ACT_RX_DONE
                         || o_out.action == i2cms_pkg::ACT_TX_DONE
                         || o_out.action == i2cms_pkg::ACT_ERR_END))
        |-> (o_out.busy_state == i2cms_pkg::MODE_READY))
        else $error("transfer ended without returning to ready");

    // a delivered byte never coincides with a data register write
    a_rx_no_dr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.rx_valid) |-> !o_out.dr_write)
        else $error("rx beat and data register write at once");

    // a started transfer clears errors and is busy
    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.action == i2cms_pkg::ACT_START)
        |-> (o_out.error_flags == 4'd0
             && o_out.busy_state != i2cms_pkg::MODE_READY))
        else $error("start issued with stale errors or in ready mode");
`endif

endmodule
